/* src/cxl_pkg.sv */
// Shared constants and types for the XYZ to L*a*b* converter.
package cxl_pkg;

   // Default input sample width.
   localparam int IN_BITS_DEF = 24;

   // Ratio t = v / w in Q2.16, saturated just under 4.0.
   localparam int RATIO_BITS = 18;
   localparam int DIV_STEPS = RATIO_BITS;

   // Channel function value f in Q1.16 and the cube root datapath.
   localparam int F_BITS = 17;
   localparam int CBRT_STEPS = F_BITS;
   localparam int CR_BITS = 51;
   localparam int F2_BITS = 34;
   localparam int D_BITS = 54;

   // Epsilon = 216 / 24389 and kappa = 24389 / 27.
   localparam int EPS_NUM = 216;
   localparam int EPS_DEN = 24389;

   // Linear segment: floor((24389 * t + 28311552 + 1566) / 3132), with 3132 = 4 * 783.
   localparam int LIN_T_BITS = 10;
   localparam int LIN_N_BITS = 26;
   localparam int LIN_M_BITS = 24;
   localparam int LIN_Q_BITS = 15;
   localparam int LIN_P_BITS = 49;
   localparam int LIN_SHIFT = 34;
   localparam int LIN_BIAS = 28311552 + 1566;
   localparam int LIN_DIV4 = 783;
   localparam longint LIN_RECIP = (longint'(1) << LIN_SHIFT) / LIN_DIV4;
   localparam int LIN_DELAY = 14;

   // Pipeline depths.
   localparam int CHAN_LAT = 1 + DIV_STEPS + CBRT_STEPS + 1;
   localparam int OUT_LAT = CHAN_LAT + 2;

   // Result widths.
   localparam int L_BITS = 16;
   localparam int A_BITS = 19;
   localparam int B_BITS = 18;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_WHITE_X = 2'd0,
      REG_WHITE_Y = 2'd1,
      REG_WHITE_Z = 2'd2
   } reg_index_type;

endpackage

/* src/cie_xyz_to_lab_convert.sv */
// Top level of the XYZ to L*a*b* converter.
//
// Pixels arrive on the req_ channel as X, Y and Z samples and leave on the
// rsp_ channel as L*, a* and b* in units of 1/256. Both channels move one
// beat per cycle when valid and ready are high together.
// The csr_ channel writes the reference white: index 0, 1 and 2 select
// white X, Y and Z; other indexes are ignored. Write it only while no pixel
// is in flight.
// An accepted req_ beat passes the entry register, the 18 quotient bits of
// the ratio divider and the 17 bits of the cube root, each a stage of its
// own, then the rounding, scaling and output registers to its rsp_ beat. One
// pixel is taken every cycle while no result waits on a low rsp_ready.
// Reset empties the pipeline and sets each white component to 24'hFFFFFF.
// When the receiver holds rsp_ready low with a result waiting, the whole
// pipeline freezes and req_ready drops; nothing is lost or repeated.
module cie_xyz_to_lab_convert #(
   parameter int IN_BITS = cxl_pkg::IN_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [IN_BITS-1:0]                 req_x_value,
   input  logic [IN_BITS-1:0]                 req_y_value,
   input  logic [IN_BITS-1:0]                 req_z_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [cxl_pkg::L_BITS-1:0]         rsp_lightness,
   output logic signed [cxl_pkg::A_BITS-1:0]  rsp_green_red,
   output logic signed [cxl_pkg::B_BITS-1:0]  rsp_blue_yellow,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cxl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [IN_BITS-1:0]                 csr_data
);
   import cxl_pkg::*;

   // Reference white registers.
   logic [IN_BITS-1:0] white_x_ff;
   logic [IN_BITS-1:0] white_y_ff;
   logic [IN_BITS-1:0] white_z_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         white_x_ff <= IN_BITS'(24'hFFFFFF);
         white_y_ff <= IN_BITS'(24'hFFFFFF);
         white_z_ff <= IN_BITS'(24'hFFFFFF);
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_WHITE_X: white_x_ff <= csr_data;
            REG_WHITE_Y: white_y_ff <= csr_data;
            REG_WHITE_Z: white_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The pipeline advances unless a finished beat is waiting on the receiver.
   logic en;
   logic vld_ff[OUT_LAT];

   assign en        = !vld_ff[OUT_LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[OUT_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < OUT_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < OUT_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // Per-channel f values.
   logic [F_BITS-1:0] fx;
   logic [F_BITS-1:0] fy;
   logic [F_BITS-1:0] fz;

   cxl_channel #(.IN_BITS(IN_BITS)) u_chan_x (
      .clock (clock), .en (en), .value (req_x_value), .white (white_x_ff), .f_out (fx)
   );
   cxl_channel #(.IN_BITS(IN_BITS)) u_chan_y (
      .clock (clock), .en (en), .value (req_y_value), .white (white_y_ff), .f_out (fy)
   );
   cxl_channel #(.IN_BITS(IN_BITS)) u_chan_z (
      .clock (clock), .en (en), .value (req_z_value), .white (white_z_ff), .f_out (fz)
   );

   // Scaling products: 116 fy, 125 (fx - fy) and 25 (fy - fz).
   logic        [23:0] lp_ff;
   logic signed [24:0] ap_ff;
   logic signed [22:0] bp_ff;
   logic signed [17:0] diff_a;
   logic signed [17:0] diff_b;

   assign diff_a = $signed({1'b0, fx}) - $signed({1'b0, fy});
   assign diff_b = $signed({1'b0, fy}) - $signed({1'b0, fz});

   always_ff @(posedge clock) begin
      if (en) begin
         lp_ff <= 24'(fy) * 24'd116;
         ap_ff <= 25'(diff_a) * 25'sd125;
         bp_ff <= 23'(diff_b) * 23'sd25;
      end
   end

   // Round half up, clamp lightness at zero and register the result beat.
   logic signed [25:0] l_sum;
   logic signed [24:0] a_sum;
   logic signed [22:0] b_sum;

   assign l_sum = $signed({2'b00, lp_ff}) - 26'sd1048448;
   assign a_sum = ap_ff + 25'sd32;
   assign b_sum = bp_ff + 23'sd16;

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_lightness   <= l_sum[25] ? '0 : l_sum[23:8];
         rsp_green_red   <= a_sum[24:6];
         rsp_blue_yellow <= b_sum[22:5];
      end
   end

endmodule

/* src/cxl_channel.sv */
// One color channel: ratio divider, cube root and linear segment, giving f in Q1.16.
module cxl_channel #(
   parameter int IN_BITS = cxl_pkg::IN_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [IN_BITS-1:0]         value,
   input  logic [IN_BITS-1:0]         white,
   output logic [cxl_pkg::F_BITS-1:0] f_out
);
   import cxl_pkg::*;

   localparam int PV_BITS = IN_BITS + 15;
   localparam int PW_BITS = IN_BITS + 8;

   // Entry stage: epsilon products and the saturation test.
   logic [IN_BITS-1:0] v_ff;
   logic [PV_BITS-1:0] pv_ff;
   logic [PW_BITS-1:0] pw_ff;
   logic               zero_ff;
   logic               sat_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff    <= value;
         pv_ff   <= PV_BITS'(value) * PV_BITS'(EPS_DEN);
         pw_ff   <= PW_BITS'(white) * PW_BITS'(EPS_NUM);
         zero_ff <= (white == '0);
         sat_ff  <= (white == '0) || ({2'b00, value} >= {white, 2'b00});
      end
   end

   logic [IN_BITS-1:0] init_r;
   logic               init_above;

   assign init_r     = v_ff >> 2;
   assign init_above = zero_ff || (pv_ff > PV_BITS'(pw_ff));

   // Restoring divider: one quotient bit per stage.
   logic [IN_BITS-1:0]    dr_ff    [DIV_STEPS];
   logic [RATIO_BITS-1:0] dq_ff    [DIV_STEPS];
   logic [1:0]            dlo_ff   [DIV_STEPS];
   logic                  dsat_ff  [DIV_STEPS];
   logic                  dabove_ff[DIV_STEPS];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [IN_BITS-1:0]    r_prev;
      logic [RATIO_BITS-1:0] q_prev;
      logic [1:0]            lo_prev;
      logic                  sat_prev;
      logic                  above_prev;
      logic                  nb;
      logic [IN_BITS:0]      shifted;
      logic [IN_BITS:0]      diff;
      logic                  take;

      if (j == 0) begin : g_first
         assign r_prev     = init_r;
         assign q_prev     = '0;
         assign lo_prev    = v_ff[1:0];
         assign sat_prev   = sat_ff;
         assign above_prev = init_above;
      end else begin : g_next
         assign r_prev     = dr_ff[j-1];
         assign q_prev     = dq_ff[j-1];
         assign lo_prev    = dlo_ff[j-1];
         assign sat_prev   = dsat_ff[j-1];
         assign above_prev = dabove_ff[j-1];
      end

      // The two low pixel bits enter in the first two steps, zeros after.
      if (j < 2) begin : g_bit
         assign nb = lo_prev[1-j];
      end else begin : g_zero
         assign nb = 1'b0;
      end

      assign shifted = {r_prev, nb};
      assign diff    = shifted - {1'b0, white};
      assign take    = (shifted >= {1'b0, white});

      always_ff @(posedge clock) begin
         if (en) begin
            dr_ff[j]     <= take ? diff[IN_BITS-1:0] : shifted[IN_BITS-1:0];
            dq_ff[j]     <= {q_prev[RATIO_BITS-2:0], take};
            dlo_ff[j]    <= lo_prev;
            dsat_ff[j]   <= sat_prev;
            dabove_ff[j] <= above_prev;
         end
      end
   end

   logic [RATIO_BITS-1:0] t_div;
   logic                  above_div;

   assign t_div     = dsat_ff[DIV_STEPS-1] ? '1 : dq_ff[DIV_STEPS-1];
   assign above_div = dabove_ff[DIV_STEPS-1];

   // Cube root by digit recurrence: keeps t*2^32 - f^3 and f^2, one bit per stage.
   logic [CR_BITS-1:0] cr_ff    [CBRT_STEPS];
   logic [F2_BITS-1:0] cf2_ff   [CBRT_STEPS];
   logic [F_BITS-1:0]  cf_ff    [CBRT_STEPS];
   logic               cabove_ff[CBRT_STEPS];

   for (genvar c = 0; c < CBRT_STEPS; c++) begin : g_cbrt
      localparam int K = CBRT_STEPS - 1 - c;
      logic [CR_BITS-1:0] r_prev;
      logic [F2_BITS-1:0] f2_prev;
      logic [F_BITS-1:0]  f_prev;
      logic               above_prev;
      logic [D_BITS-1:0]  delta;
      logic [D_BITS-1:0]  f2_next;
      logic               fit;

      if (c == 0) begin : g_first
         assign r_prev     = CR_BITS'({t_div, 32'd0});
         assign f2_prev    = '0;
         assign f_prev     = '0;
         assign above_prev = above_div;
      end else begin : g_next
         assign r_prev     = cr_ff[c-1];
         assign f2_prev    = cf2_ff[c-1];
         assign f_prev     = cf_ff[c-1];
         assign above_prev = cabove_ff[c-1];
      end

      // (f + 2^k)^3 - f^3 = 3 f^2 2^k + 3 f 2^2k + 2^3k
      assign delta = ((D_BITS'(f2_prev) + (D_BITS'(f2_prev) << 1)) << K)
                   + ((D_BITS'(f_prev) + (D_BITS'(f_prev) << 1)) << (2 * K))
                   + (D_BITS'(1) << (3 * K));
      assign fit = (D_BITS'(r_prev) >= delta);
      assign f2_next = D_BITS'(f2_prev) + (D_BITS'(f_prev) << (K + 1))
                     + (D_BITS'(1) << (2 * K));

      always_ff @(posedge clock) begin
         if (en) begin
            if (fit) begin
               cr_ff[c]  <= r_prev - delta[CR_BITS-1:0];
               cf2_ff[c] <= f2_next[F2_BITS-1:0];
               cf_ff[c]  <= f_prev | (F_BITS'(1) << K);
            end else begin
               cr_ff[c]  <= r_prev;
               cf2_ff[c] <= f2_prev;
               cf_ff[c]  <= f_prev;
            end
            cabove_ff[c] <= above_prev;
         end
      end
   end

   // Linear segment, run beside the cube root; the ratio is below 581 when it is used.
   logic [LIN_N_BITS-1:0] lin_n_ff;
   logic [LIN_M_BITS-1:0] lin_m_ff;
   logic [LIN_Q_BITS-1:0] lin_q_ff;
   logic [LIN_P_BITS-1:0] lin_p;
   logic [LIN_M_BITS-1:0] lin_m2_ff;
   logic [LIN_Q_BITS-1:0] lin_q2_ff;
   logic [LIN_M_BITS-1:0] lin_qm_ff;
   logic [LIN_M_BITS-1:0] lin_rem;
   logic [F_BITS-1:0]     lin_fix;
   logic [F_BITS-1:0]     lin_dly_ff[LIN_DELAY];

   assign lin_p   = LIN_P_BITS'(lin_n_ff[LIN_N_BITS-1:2]) * LIN_P_BITS'(LIN_RECIP);
   assign lin_rem = lin_m2_ff - lin_qm_ff;
   assign lin_fix = F_BITS'(lin_q2_ff) + F_BITS'(lin_rem >= LIN_M_BITS'(LIN_DIV4));

   always_ff @(posedge clock) begin
      if (en) begin
         lin_n_ff  <= LIN_N_BITS'(t_div[LIN_T_BITS-1:0]) * LIN_N_BITS'(EPS_DEN)
                    + LIN_N_BITS'(LIN_BIAS);
         lin_m_ff  <= lin_n_ff[LIN_N_BITS-1:2];
         lin_q_ff  <= lin_p[LIN_SHIFT+LIN_Q_BITS-1:LIN_SHIFT];
         lin_m2_ff <= lin_m_ff;
         lin_q2_ff <= lin_q_ff;
         lin_qm_ff <= LIN_M_BITS'(lin_q_ff) * LIN_M_BITS'(LIN_DIV4);
         lin_dly_ff[0] <= lin_fix;
         for (int i = 1; i < LIN_DELAY; i++) begin
            lin_dly_ff[i] <= lin_dly_ff[i-1];
         end
      end
   end

   // Round the cube root to nearest and pick the branch.
   logic [D_BITS-1:0] rnd_lhs;
   logic [D_BITS-1:0] rnd_rhs;
   logic              rnd_up;
   logic [F_BITS-1:0] f_ff;

   assign rnd_lhs = (D_BITS'(cf2_ff[CBRT_STEPS-1]) << 3) + (D_BITS'(cf2_ff[CBRT_STEPS-1]) << 2)
                  + (D_BITS'(cf_ff[CBRT_STEPS-1]) << 2) + (D_BITS'(cf_ff[CBRT_STEPS-1]) << 1)
                  + D_BITS'(1);
   assign rnd_rhs = D_BITS'(cr_ff[CBRT_STEPS-1]) << 3;
   assign rnd_up  = (rnd_lhs <= rnd_rhs);

   always_ff @(posedge clock) begin
      if (en) begin
         f_ff <= cabove_ff[CBRT_STEPS-1] ? (cf_ff[CBRT_STEPS-1] + F_BITS'(rnd_up))
                                         : lin_dly_ff[LIN_DELAY-1];
      end
   end

   assign f_out = f_ff;

endmodule

/* bench/cie_xyz_to_lab_convert_check.sv */
// Checker for the XYZ to L*a*b* converter: predicts each result from accepted beats.
module cie_xyz_to_lab_convert_check #(
   parameter int IN_BITS = cxl_pkg::IN_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [IN_BITS-1:0]                 req_x_value,
   input  logic [IN_BITS-1:0]                 req_y_value,
   input  logic [IN_BITS-1:0]                 req_z_value,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [cxl_pkg::L_BITS-1:0]         rsp_lightness,
   input  logic signed [cxl_pkg::A_BITS-1:0]  rsp_green_red,
   input  logic signed [cxl_pkg::B_BITS-1:0]  rsp_blue_yellow,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [cxl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [IN_BITS-1:0]                 csr_data,
   output int                                 fail_count,
   output int                                 pending_count,
   output int                                 lab_seen
);
   import cxl_pkg::*;

   typedef struct packed {
      logic [L_BITS-1:0]        lightness;
      logic signed [A_BITS-1:0] green_red;
      logic signed [B_BITS-1:0] blue_yellow;
   } lab_type;

   lab_type lab_queue[$];
   logic [IN_BITS-1:0] wx, wy, wz;

   // Cube root of t in Q1.16, rounded to nearest with ties upward.
   function automatic longint unsigned cbrt_q16(longint unsigned t);
      longint unsigned goal, f, c, h;
      goal = t << 32;
      f = 0;
      for (int bit_pos = 16; bit_pos >= 0; bit_pos--) begin
         c = f | (64'd1 << bit_pos);
         if (c * c * c <= goal) f = c;
      end
      h = 2 * f + 1;
      if (h * h * h <= (t << 35)) f = f + 1;
      return f;
   endfunction

   // Companding function of one channel against its white component.
   function automatic longint chan_f(longint unsigned v, longint unsigned w);
      longint unsigned t;
      bit above;
      if (w == 0) begin
         t = 262143;
         above = 1;
      end else begin
         t = (v << 16) / w;
         if (t > 262143) t = 262143;
         above = (v * EPS_DEN) > (EPS_NUM * w);
      end
      if (above) return longint'(cbrt_q16(t));
      return longint'((EPS_DEN * t + 28311552 + 1566) / 3132);
   endfunction

   // Division rounding half toward plus infinity.
   function automatic longint div_round(longint n, longint d);
      longint m, q;
      m = n + d / 2;
      q = m / d;
      if ((m % d) != 0 && m < 0) q = q - 1;
      return q;
   endfunction

   function automatic lab_type predict_lab(longint unsigned x, longint unsigned y,
                                           longint unsigned z);
      longint fx, fy, fz, l, a, b;
      lab_type r;
      fx = chan_f(x, wx);
      fy = chan_f(y, wy);
      fz = chan_f(z, wz);
      l = div_round(116 * fy - 1048576, 256);
      a = div_round(125 * (fx - fy), 64);
      b = div_round(25 * (fy - fz), 32);
      if (l < 0) l = 0;
      if (l > 65535) l = 65535;
      r.lightness = l[L_BITS-1:0];
      r.green_red = a[A_BITS-1:0];
      r.blue_yellow = b[B_BITS-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // Track white registers, queue predictions and compare result beats.
   always @(posedge clock) begin
      lab_type want;
      if (reset) begin
         wx <= IN_BITS'(24'hFFFFFF);
         wy <= IN_BITS'(24'hFFFFFF);
         wz <= IN_BITS'(24'hFFFFFF);
         lab_queue.delete();
         fail_count <= 0;
         lab_seen <= 0;
      end else begin
         if (req_valid && req_ready)
            lab_queue.push_back(predict_lab(req_x_value, req_y_value, req_z_value));
         if (rsp_valid && rsp_ready) begin
            lab_seen <= lab_seen + 1;
            if (lab_queue.size() == 0) begin
               report_mismatch("unexpected beat", rsp_lightness, -1);
            end else begin
               want = lab_queue.pop_front();
               if (rsp_lightness !== want.lightness)
                  report_mismatch("lightness", rsp_lightness, want.lightness);
               if (rsp_green_red !== want.green_red)
                  report_mismatch("green_red", rsp_green_red, want.green_red);
               if (rsp_blue_yellow !== want.blue_yellow)
                  report_mismatch("blue_yellow", rsp_blue_yellow, want.blue_yellow);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_WHITE_X: wx <= csr_data;
               REG_WHITE_Y: wy <= csr_data;
               REG_WHITE_Z: wz <= csr_data;
               default: ;
            endcase
         end
      end
      pending_count = lab_queue.size();
   end
endmodule

/* bench/cie_xyz_to_lab_convert_test.sv */
// Stimulus and verdict for the XYZ to L*a*b* converter.
module cie_xyz_to_lab_convert_test;
   import cxl_pkg::*;

   localparam int W = IN_BITS_DEF;
   localparam int LAT = OUT_LAT + 4;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   logic [W-1:0] req_x_value, req_y_value, req_z_value, csr_data;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [L_BITS-1:0] rsp_lightness;
   logic signed [A_BITS-1:0] rsp_green_red;
   logic signed [B_BITS-1:0] rsp_blue_yellow;
   int fail_count, pending_count, lab_seen;
   int hold_off;
   bit calm;
   logic [W-1:0] wcur[3];

   cie_xyz_to_lab_convert #(.IN_BITS(W)) DUT (.*);
   cie_xyz_to_lab_convert_check #(.IN_BITS(W)) checker_inst (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("FAIL cie_xyz_to_lab_convert");
      $finish;
   end

   // Receiver: random stalls, a long hold-off when asked, none while calm.
   initial begin
      rsp_ready = 0;
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            hold_off--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 12);
         end
      end
   end

   task automatic idle_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   // Send one pixel beat, possibly after a random gap; valid drops only in a gap.
   task automatic send_pixel(logic [W-1:0] x, logic [W-1:0] y, logic [W-1:0] z);
      if (!calm)
         while ($urandom_range(99) < 12) begin
            req_valid <= 0;
            idle_cycles(1);
         end
      req_valid <= 1;
      req_x_value <= x;
      req_y_value <= y;
      req_z_value <= z;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 0;
      idle_cycles(1);
      while (pending_count != 0) idle_cycles(1);
      idle_cycles(LAT);
   endtask

   task automatic write_reg(reg_index_type idx, logic [W-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
      if (idx <= REG_WHITE_Z) wcur[idx] = val;
   endtask

   // Random channel value, mostly from zero up to the white, to cover both segments.
   function automatic logic [W-1:0] pick_value(logic [W-1:0] w);
      int sel;
      longint unsigned v;
      sel = $urandom_range(9);
      case (sel)
         0: v = $urandom & 24'hFFFFFF;
         1: v = (longint'(w) * $urandom_range(0, 400)) / 24389;
         2: v = $urandom_range(3);
         3: v = (longint'(w) * $urandom_range(3, 5)) / 1;
         default: v = (longint'(w) * $urandom_range(0, 1000)) / 1000;
      endcase
      if (v > 24'hFFFFFF) v = 24'hFFFFFF;
      return v[W-1:0];
   endfunction

   initial begin
      logic [W-1:0] w_sets[6][3];
      logic [W-1:0] e;
      reset = 1;
      req_valid = 0;
      csr_valid = 0;
      req_x_value = 0;
      req_y_value = 0;
      req_z_value = 0;
      csr_index = REG_WHITE_X;
      csr_data = 0;
      hold_off = 0;
      calm = 0;
      wcur[0] = '1;
      wcur[1] = '1;
      wcur[2] = '1;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes at reset white.
      send_pixel('0, '0, '0);
      send_pixel('1, '1, '1);
      send_pixel('1, '0, '1);
      send_pixel('0, '1, '0);
      send_pixel(24'h555555, 24'hAAAAAA, 24'h0F0F0F);
      drain();

      // Small white: epsilon boundary, saturation above white.
      write_reg(REG_WHITE_X, 24389);
      write_reg(REG_WHITE_Y, 24389);
      write_reg(REG_WHITE_Z, 1);
      write_reg(reg_index_type'(2'd3), 24'h123456);
      send_pixel(216, 216, 0);
      send_pixel(217, 215, 1);
      send_pixel(24'hFFFFFF, 24389, 24'hFFFFFF);
      send_pixel(1, 97560, 2);
      drain();

      // Zero white components take the cube-root path at full ratio.
      write_reg(REG_WHITE_X, 0);
      write_reg(REG_WHITE_Y, 0);
      write_reg(REG_WHITE_Z, 0);
      send_pixel(0, 0, 0);
      send_pixel('1, 5, 24'h800000);
      drain();
      write_reg(REG_WHITE_Y, 1000000);
      send_pixel(0, 8856, 3);
      send_pixel(7, 8857, 0);
      send_pixel(1, 4000000, 1);
      drain();

      w_sets[0] = '{24'd15_000_000, 24'd16_000_000, 24'd13_000_000};
      w_sets[1] = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
      w_sets[2] = '{24'd1, 24'd1, 24'd1};
      w_sets[3] = '{24'd95047, 24'd100000, 24'd108883};
      w_sets[4] = '{24'h800000, 24'h7FFFFF, 24'h400001};
      w_sets[5] = '{24'd300, 24'd9_000_000, 24'd65536};

      for (int ph = 0; ph < 6; ph++) begin
         write_reg(REG_WHITE_X, w_sets[ph][0]);
         write_reg(REG_WHITE_Y, w_sets[ph][1]);
         write_reg(REG_WHITE_Z, w_sets[ph][2]);
         calm = (ph == 2);
         if (ph == 1) hold_off = 200;
         for (int i = 0; i < 300; i++)
            send_pixel(pick_value(wcur[0]), pick_value(wcur[1]), pick_value(wcur[2]));
         calm = 0;
         drain();
      end

      // Every input bit both ways with the last white setting.
      for (int b = 0; b < W; b++) begin
         e = W'(1) << b;
         send_pixel(e, ~e, e);
      end
      drain();

      $display("covered %0d pixels over nine white settings, epsilon edges, zero white,",
               lab_seen);
      $display("saturation, a long receiver hold-off and full-rate stretches");
      if (fail_count == 0)
         $display("PASS cie_xyz_to_lab_convert");
      else
         $display("FAIL cie_xyz_to_lab_convert");
      $finish;
   end
endmodule
